@@ sv/hdr_to_ldr_gamma_pack_unit_assert.svh @@
// ---------------------------------------------------------------------------
// HDR to LDR gamma pack: assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef HDR_TO_LDR_GAMMA_PACK_UNIT_ASSERT_SVH
`define HDR_TO_LDR_GAMMA_PACK_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define HGP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hgp assertion failed");

`define HGP_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    `HGP_ASSERT(lbl, clk, rst_n, !(expr))

`else

`define HGP_ASSERT(lbl, clk, rst_n, prop)

`define HGP_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

@@ sv/hgp_pkg.sv @@
// ---------------------------------------------------------------------------
// HDR to LDR gamma pack: package
// Shared constants, types and the exponent factor table.
// ---------------------------------------------------------------------------
package hgp_pkg;

    localparam int LOG_STEPS = 16;
    localparam int EXP_STEPS = 16;
    localparam int LANE_LAT  = LOG_STEPS + EXP_STEPS + 6;
    localparam int QD_LAST   = LOG_STEPS + EXP_STEPS + 2;

    localparam int DIM_BITS  = 13;
    localparam logic [DIM_BITS-1:0] MAX_WIDTH  = 13'd4096;
    localparam logic [DIM_BITS-1:0] MAX_HEIGHT = 13'd4096;

    localparam logic [16:0] Q_ONE         = 17'h10000;
    localparam logic [31:0] SRGB_EXP      = 32'd27306;
    localparam logic [16:0] SRGB_LIN_MAX  = 17'd205;
    localparam logic [19:0] SRGB_SLOPE    = 20'd846725;
    localparam logic [16:0] SRGB_GAIN     = 17'd69140;
    localparam logic [17:0] SRGB_OFFSET   = 18'd3604;
    localparam logic [31:0] GAMMA_24_BITS = 32'h4019999A;
    localparam logic [31:0] GAMMA_NEAR    = 32'd41;
    localparam logic [31:0] P_MAX         = 32'hFFFFFFFF;
    localparam logic [5:0]  DIV_STEPS     = 6'd56;

    localparam logic [31:0] NORM_RESET  = 32'h3F800000;
    localparam logic [31:0] GAMMA_RESET = 32'h4019999A;

    typedef enum logic [1:0] {
        MODE_SRGB,
        MODE_POW,
        MODE_ZERO,
        MODE_ONE
    } t_mode;

    typedef enum logic [2:0] {
        REG_NORM   = 3'd0,
        REG_GAMMA  = 3'd1,
        REG_MONO   = 3'd2,
        REG_FLIP   = 3'd3,
        REG_WIDTH  = 3'd4,
        REG_HEIGHT = 3'd5
    } t_cfg_reg;

    typedef enum logic {
        DIV_IDLE,
        DIV_RUN
    } t_div_state;

    typedef struct packed {
        logic [31:0]         norm;
        logic [31:0]         pexp;
        t_mode               mode;
        logic                mono;
        logic                flip;
        logic [DIM_BITS-1:0] width;
        logic [DIM_BITS-1:0] height;
    } t_cfg;

    typedef logic [EXP_STEPS:0][31:0] t_dtab;

    function automatic logic [63:0] f_isqrt64(input logic [63:0] a);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = a;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (int j = 0; j < 32; j++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_dtab f_build_dtab();
        t_dtab       tab;
        logic [63:0] d;
        d = 64'h8000_0000;
        tab[0] = 32'h8000_0000;
        for (int i = 1; i <= EXP_STEPS; i++) begin
            d = f_isqrt64(d << 32);
            tab[i] = d[31:0];
        end
        return tab;
    endfunction

    localparam t_dtab D_TAB = f_build_dtab();

endpackage

@@ sv/hgp_cfg.sv @@
// ---------------------------------------------------------------------------
// HDR to LDR gamma pack: configuration registers
// Holds the registers and derives the curve exponent, directly or with a serial divider.
// ---------------------------------------------------------------------------
module hgp_cfg
    import hgp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_busy,
    output t_cfg        o_cfg
);

`include "hdr_to_ldr_gamma_pack_unit_assert.svh"

    logic [31:0]         r_norm;
    logic [31:0]         r_gamma;
    logic                r_mono;
    logic                r_flip;
    logic [DIM_BITS-1:0] r_width;
    logic [DIM_BITS-1:0] r_height;
    logic [31:0]         r_p;
    logic [31:0]         n_p;

    t_div_state r_state;
    t_div_state n_state;
    logic [23:0] r_div;
    logic [5:0]  r_sh;
    logic [5:0]  r_cnt;
    logic [23:0] r_rem;
    logic [55:0] r_quo;

    logic        wr;
    logic        wr_gamma;
    logic [7:0]  w_ge;
    logic [22:0] w_gm;
    logic [7:0]  w_ee;
    logic [8:0]  w_sh;
    logic        need_div;
    logic        p_direct;
    logic [24:0] d_rem2;
    logic        d_ge;
    logic [23:0] n_rem;
    logic [55:0] n_quo;
    logic [7:0]  g_e;
    logic [22:0] g_m;

    assign wr       = i_cfg_valid && o_cfg_ready;
    assign wr_gamma = wr && (i_cfg_index == REG_GAMMA);

    // exponent setup from the new gamma value
    always_comb begin
        w_ge     = i_cfg_data[30:23];
        w_gm     = i_cfg_data[22:0];
        w_ee     = (w_ge == 8'd0) ? 8'd1 : w_ge;
        w_sh     = 9'd166 - {1'b0, w_ee};
        need_div = 1'b0;
        p_direct = 1'b0;
        n_p      = '0;
        if (w_ge == 8'hFF) begin
            n_p      = '0;
            p_direct = 1'b1;
        end else if (w_ge == 8'd0 && w_gm == 23'd0) begin
            n_p      = P_MAX;
            p_direct = 1'b1;
        end else if (w_ee > 8'd166) begin
            n_p      = '0;
            p_direct = 1'b1;
        end else if (w_sh >= {3'b0, DIV_STEPS}) begin
            n_p      = P_MAX;
            p_direct = 1'b1;
        end else begin
            need_div = 1'b1;
        end
    end

    always_comb begin
        d_rem2 = {r_rem, (r_cnt == r_sh)};
        d_ge   = (d_rem2 >= {1'b0, r_div});
        n_rem  = d_ge ? 24'(d_rem2 - {1'b0, r_div}) : d_rem2[23:0];
        n_quo  = {r_quo[54:0], d_ge};
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            DIV_IDLE: begin
                if (wr_gamma && need_div) n_state = DIV_RUN;
            end
            DIV_RUN: begin
                if (r_cnt == 6'd0) n_state = DIV_IDLE;
            end
            default: n_state = DIV_IDLE;
        endcase
    end

    always_comb begin
        case (r_state)
            DIV_IDLE: begin
                o_busy      = 1'b0;
                o_cfg_ready = 1'b1;
            end
            DIV_RUN: begin
                o_busy      = 1'b1;
                o_cfg_ready = 1'b0;
            end
            default: begin
                o_busy      = 1'b0;
                o_cfg_ready = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= DIV_IDLE;
            r_norm   <= NORM_RESET;
            r_gamma  <= GAMMA_RESET;
            r_mono   <= 1'b0;
            r_flip   <= 1'b0;
            r_width  <= MAX_WIDTH;
            r_height <= MAX_HEIGHT;
            r_p      <= '0;
        end else begin
            r_state <= n_state;
            if (wr) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_NORM:   r_norm   <= i_cfg_data;
                    REG_GAMMA:  r_gamma  <= i_cfg_data;
                    REG_MONO:   r_mono   <= i_cfg_data[0];
                    REG_FLIP:   r_flip   <= i_cfg_data[0];
                    REG_WIDTH:  r_width  <= i_cfg_data[DIM_BITS-1:0];
                    REG_HEIGHT: r_height <= i_cfg_data[DIM_BITS-1:0];
                    default: ;
                endcase
            end
            if (wr_gamma && p_direct) r_p <= n_p;
            if (r_state == DIV_RUN && r_cnt == 6'd0) begin
                r_p <= (|n_quo[55:32]) ? P_MAX : n_quo[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == DIV_IDLE) begin
            r_div <= w_ge == 8'd0 ? {1'b0, w_gm} : {1'b1, w_gm};
            r_sh  <= w_sh[5:0];
            r_cnt <= DIV_STEPS - 6'd1;
            r_rem <= '0;
            r_quo <= '0;
        end else begin
            r_cnt <= r_cnt - 6'd1;
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    // output view of the registers
    always_comb begin
        g_e = r_gamma[30:23];
        g_m = r_gamma[22:0];
        if (r_gamma >= GAMMA_24_BITS - GAMMA_NEAR && r_gamma <= GAMMA_24_BITS + GAMMA_NEAR) begin
            o_cfg.mode = MODE_SRGB;
        end else if (g_e == 8'hFF && g_m != 23'd0) begin
            o_cfg.mode = MODE_ZERO;
        end else if (r_gamma[31]) begin
            o_cfg.mode = MODE_ONE;
        end else begin
            o_cfg.mode = MODE_POW;
        end
        o_cfg.pexp   = (o_cfg.mode == MODE_SRGB) ? SRGB_EXP : r_p;
        o_cfg.norm   = r_norm;
        o_cfg.mono   = r_mono;
        o_cfg.flip   = r_flip;
        o_cfg.width  = (r_width == '0) ? DIM_BITS'(1) :
                       (r_width > MAX_WIDTH) ? MAX_WIDTH : r_width;
        o_cfg.height = (r_height == '0) ? DIM_BITS'(1) :
                       (r_height > MAX_HEIGHT) ? MAX_HEIGHT : r_height;
    end

    `HGP_ASSERT(a_busy_from_gamma, i_clk, i_rst_n, $rose(o_busy) |-> $past(wr_gamma))
    `HGP_ASSERT(a_div_ends, i_clk, i_rst_n, (r_state == DIV_RUN && r_cnt == 6'd0) |=> (r_state == DIV_IDLE))

endmodule

@@ sv/hgp_lane.sv @@
// ---------------------------------------------------------------------------
// HDR to LDR gamma pack: channel lane
// Scales one float channel, applies the transfer curve, returns its byte.
// ---------------------------------------------------------------------------
module hgp_lane
    import hgp_pkg::*;
(
    input  logic        i_clk,
    input  logic [31:0] i_bits,
    input  logic [31:0] i_norm,
    input  t_mode       i_mode,
    input  logic [31:0] i_pexp,
    output logic [7:0]  o_byte
);

    // scale stage
    logic        r_a_force;
    logic [16:0] r_a_fval;
    logic [47:0] r_a_prod;
    logic signed [9:0] r_a_sh;
    logic        n_a_force;
    logic [16:0] n_a_fval;
    logic [47:0] n_a_prod;
    logic signed [9:0] n_a_sh;
    logic [7:0]  a_ea;
    logic [7:0]  a_eb;
    logic [22:0] a_ma;
    logic [22:0] a_mb;
    logic        a_neg;
    logic        a_za;
    logic        a_zb;
    logic [23:0] a_mah;
    logic [23:0] a_mbh;
    logic [7:0]  a_eaa;
    logic [7:0]  a_ebb;

    // clamp stage
    logic [16:0] r_b_q;
    logic [16:0] n_b_q;
    logic [63:0] b_wide;
    logic [9:0]  b_nsh;

    // log stages, index 0 is the normalize stage
    logic [16:0] r_lz [0:LOG_STEPS];
    logic [15:0] r_lf [0:LOG_STEPS];
    logic [4:0]  r_lk [0:LOG_STEPS];
    logic [16:0] n_lz [1:LOG_STEPS];
    logic [15:0] n_lf [1:LOG_STEPS];
    logic [33:0] l_sq [1:LOG_STEPS];
    logic [4:0]  c_k;
    logic [31:0] c_z32;
    logic [27:0] c_lin28;

    // q and linear segment carried to the end
    logic [16:0] r_qd [0:QD_LAST];
    logic [11:0] r_ld [0:QD_LAST];

    // exponent stages, index 0 is the product stage
    logic [32:0] r_er [0:EXP_STEPS];
    logic [36:0] r_et [0:EXP_STEPS];
    logic [32:0] n_er [1:EXP_STEPS];
    logic [64:0] e_pr [1:EXP_STEPS];
    logic [20:0] m_l;
    logic [52:0] m_t;

    // finish stages
    logic [16:0] r_f_y;
    logic [17:0] r_f_s;
    logic [16:0] n_f_y;
    logic [33:0] f_s34;
    logic [20:0] f_n;
    logic [16:0] f_q;
    logic [7:0]  r_g_byte;
    logic [7:0]  n_g_byte;
    logic [16:0] g_y;
    logic [17:0] g_d;
    logic [24:0] g_m;

    always_comb begin
        a_ea  = i_bits[30:23];
        a_eb  = i_norm[30:23];
        a_ma  = i_bits[22:0];
        a_mb  = i_norm[22:0];
        a_neg = i_bits[31] ^ i_norm[31];
        a_za  = (a_ea == 8'd0) && (a_ma == 23'd0);
        a_zb  = (a_eb == 8'd0) && (a_mb == 23'd0);
        n_a_force = 1'b1;
        n_a_fval  = '0;
        if ((a_ea == 8'hFF && a_ma != 23'd0) || (a_eb == 8'hFF && a_mb != 23'd0)) begin
            n_a_fval = '0;
        end else if (a_ea == 8'hFF || a_eb == 8'hFF) begin
            n_a_fval = (a_za || a_zb || a_neg) ? 17'd0 : Q_ONE;
        end else if (a_za || a_zb || a_neg) begin
            n_a_fval = '0;
        end else begin
            n_a_force = 1'b0;
        end
        a_mah    = {(a_ea != 8'd0), a_ma};
        a_mbh    = {(a_eb != 8'd0), a_mb};
        a_eaa    = (a_ea == 8'd0) ? 8'd1 : a_ea;
        a_ebb    = (a_eb == 8'd0) ? 8'd1 : a_eb;
        n_a_prod = a_mah * a_mbh;
        n_a_sh   = $signed({2'b00, a_eaa}) + $signed({2'b00, a_ebb}) - 10'sd284;
    end

    always_comb begin
        b_wide = '0;
        b_nsh  = 10'(-r_a_sh);
        n_b_q  = '0;
        if (r_a_force) begin
            n_b_q = r_a_fval;
        end else if (r_a_sh >= 10'sd17) begin
            n_b_q = Q_ONE;
        end else if (r_a_sh >= 10'sd0) begin
            b_wide = {16'b0, r_a_prod} << r_a_sh[4:0];
            n_b_q  = (b_wide > 64'(Q_ONE)) ? Q_ONE : b_wide[16:0];
        end else if (b_nsh < 10'd64) begin
            b_wide = {16'b0, r_a_prod} >> b_nsh[5:0];
            n_b_q  = (b_wide > 64'(Q_ONE)) ? Q_ONE : b_wide[16:0];
        end
    end

    always_comb begin
        c_k = '0;
        for (int i = 0; i < 17; i++) begin
            if (r_b_q[i]) c_k = 5'(i);
        end
        c_z32   = {15'b0, r_b_q} << (5'd16 - c_k);
        c_lin28 = r_b_q[7:0] * SRGB_SLOPE;
    end

    always_comb begin
        for (int i = 1; i <= LOG_STEPS; i++) begin
            l_sq[i] = r_lz[i-1] * r_lz[i-1];
            if (l_sq[i][33]) begin
                n_lz[i] = l_sq[i][33:17];
                n_lf[i] = r_lf[i-1] | (16'd1 << (LOG_STEPS - i));
            end else begin
                n_lz[i] = l_sq[i][32:16];
                n_lf[i] = r_lf[i-1];
            end
        end
    end

    always_comb begin
        m_l = {5'd16 - r_lk[LOG_STEPS], 16'b0} - {5'b0, r_lf[LOG_STEPS]};
        m_t = m_l * i_pexp;
    end

    always_comb begin
        for (int i = 1; i <= EXP_STEPS; i++) begin
            e_pr[i] = r_er[i-1] * D_TAB[i];
            n_er[i] = r_et[i-1][EXP_STEPS-i] ? e_pr[i][64:32] : r_er[i-1];
        end
    end

    always_comb begin
        f_n = r_et[EXP_STEPS][36:16];
        f_q = r_qd[QD_LAST-1];
        if (f_q == 17'd0) begin
            n_f_y = (i_pexp == 32'd0) ? Q_ONE : 17'd0;
        end else if (f_n >= 21'd17) begin
            n_f_y = '0;
        end else begin
            n_f_y = 17'(r_er[EXP_STEPS] >> (6'd16 + {1'b0, f_n[4:0]}));
        end
        f_s34 = SRGB_GAIN * n_f_y;
    end

    always_comb begin
        g_y = r_f_y;
        g_d = r_f_s - SRGB_OFFSET;
        if (i_mode == MODE_SRGB) begin
            if (r_qd[QD_LAST] <= SRGB_LIN_MAX) begin
                g_y = {5'b0, r_ld[QD_LAST]};
            end else if (r_f_s <= SRGB_OFFSET) begin
                g_y = '0;
            end else begin
                g_y = (g_d > {1'b0, Q_ONE}) ? Q_ONE : g_d[16:0];
            end
        end
        g_m = {g_y, 8'b0} - {8'b0, g_y};
        case (i_mode)
            MODE_ZERO: n_g_byte = 8'h00;
            MODE_ONE:  n_g_byte = 8'hFF;
            default:   n_g_byte = g_m[23:16];
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_a_force <= n_a_force;
        r_a_fval  <= n_a_fval;
        r_a_prod  <= n_a_prod;
        r_a_sh    <= n_a_sh;
        r_b_q     <= n_b_q;
        r_lz[0]   <= c_z32[16:0];
        r_lf[0]   <= '0;
        r_lk[0]   <= c_k;
        r_qd[0]   <= r_b_q;
        r_ld[0]   <= c_lin28[27:16];
        for (int i = 1; i <= LOG_STEPS; i++) begin
            r_lz[i] <= n_lz[i];
            r_lf[i] <= n_lf[i];
            r_lk[i] <= r_lk[i-1];
        end
        for (int i = 1; i <= QD_LAST; i++) begin
            r_qd[i] <= r_qd[i-1];
            r_ld[i] <= r_ld[i-1];
        end
        r_er[0] <= 33'h1_0000_0000;
        r_et[0] <= m_t[52:16];
        for (int i = 1; i <= EXP_STEPS; i++) begin
            r_er[i] <= n_er[i];
            r_et[i] <= r_et[i-1];
        end
        r_f_y    <= n_f_y;
        r_f_s    <= f_s34[33:16];
        r_g_byte <= n_g_byte;
    end

    assign o_byte = r_g_byte;

endmodule

@@ sv/hdr_to_ldr_gamma_pack_unit.sv @@
// ---------------------------------------------------------------------------
// HDR to LDR gamma pack unit
// Converts float RGB pixels to packed RGBA8 words with frame addresses.
//
//   channel   handshake                  payload
//   input     start & !busy              i_red/green/blue_bits, i_column, i_row
//   result    o_strobe (one cycle)       o_packed_pixel, o_pixel_index
//   config    i_cfg_valid & o_cfg_ready  i_cfg_index, i_cfg_data
//
// One item per cycle while busy is low; each result passes through
// the 16 log squaring stages and 16 exponent product stages per lane.
// A gamma write that needs a quotient starts the serial exponent divider;
// busy is high meanwhile.
// Synchronous active-low reset clears the valid pipe and the configuration registers.
// Results are never held back: the pipe advances every cycle.
// ---------------------------------------------------------------------------
module hdr_to_ldr_gamma_pack_unit
    import hgp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_red_bits,
    input  logic [31:0] i_green_bits,
    input  logic [31:0] i_blue_bits,
    input  logic [11:0] i_column,
    input  logic [11:0] i_row,
    output logic        o_strobe,
    output logic [31:0] o_packed_pixel,
    output logic [23:0] o_pixel_index,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

`include "hdr_to_ldr_gamma_pack_unit_assert.svh"

    t_cfg        cfg;
    logic        accept;
    logic [LANE_LAT-1:0] r_vld;
    logic [23:0] r_idx [0:LANE_LAT-1];
    logic [23:0] a_yrow;
    logic [36:0] a_prod;
    logic [7:0]  byte_r;
    logic [7:0]  byte_g;
    logic [7:0]  byte_b;

    assign accept = start && !busy;

    hgp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_busy      (busy),
        .o_cfg       (cfg)
    );

    hgp_lane u_lane_r (
        .i_clk  (i_clk),
        .i_bits (i_red_bits),
        .i_norm (cfg.norm),
        .i_mode (cfg.mode),
        .i_pexp (cfg.pexp),
        .o_byte (byte_r)
    );

    hgp_lane u_lane_g (
        .i_clk  (i_clk),
        .i_bits (cfg.mono ? i_red_bits : i_green_bits),
        .i_norm (cfg.norm),
        .i_mode (cfg.mode),
        .i_pexp (cfg.pexp),
        .o_byte (byte_g)
    );

    hgp_lane u_lane_b (
        .i_clk  (i_clk),
        .i_bits (cfg.mono ? i_red_bits : i_blue_bits),
        .i_norm (cfg.norm),
        .i_mode (cfg.mode),
        .i_pexp (cfg.pexp),
        .o_byte (byte_b)
    );

    always_comb begin
        a_yrow = cfg.flip ? (24'(cfg.height) - 24'd1 - 24'(i_row)) : 24'(i_row);
        a_prod = a_yrow * cfg.width;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LANE_LAT-2:0], accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx[0] <= a_prod[23:0] + {12'b0, i_column};
        for (int i = 1; i < LANE_LAT; i++) begin
            r_idx[i] <= r_idx[i-1];
        end
    end

    assign o_strobe       = r_vld[LANE_LAT-1];
    assign o_packed_pixel = {8'hFF, byte_b, byte_g, byte_r};
    assign o_pixel_index  = r_idx[LANE_LAT-1];

    `HGP_ASSERT(a_item_returns, i_clk, i_rst_n, accept |-> ##LANE_LAT o_strobe)
    `HGP_ASSERT(a_no_invented, i_clk, i_rst_n, o_strobe |-> $past(accept, LANE_LAT))
    `HGP_ASSERT_NEVER(a_no_cfg_while_busy, i_clk, i_rst_n, busy && o_cfg_ready)

endmodule
